[rtl/sfd_pkg.sv]
// Shared types, constants and functions of the serial frame deframer.
// Depends on nothing; used by sfd_cell, serial_frame_deframer_descramble_crc and tb_top.
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int DefBufferBytes = 64;
    localparam int KeyBytes       = 16;

    localparam logic [7:0] UiSync     = 8'hB5;
    localparam logic [7:0] PktSync0   = 8'hAB;
    localparam logic [7:0] PktSync1   = 8'hCD;
    localparam logic [7:0] PktTrail0  = 8'hDC;
    localparam logic [7:0] PktTrail1  = 8'hBA;
    localparam logic [7:0] UiNoData   = 8'h06;
    localparam logic [15:0] CrcPoly   = 16'h1021;
    localparam logic [15:0] DiscMax   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_DECIDE,
        ST_EMIT
    } sfd_state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] din;
    } cell_ctl_t;

    function automatic logic [7:0] scramble_key(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:  k = 8'h16;
            4'd1:  k = 8'h6c;
            4'd2:  k = 8'h14;
            4'd3:  k = 8'he6;
            4'd4:  k = 8'h2e;
            4'd5:  k = 8'h91;
            4'd6:  k = 8'h0d;
            4'd7:  k = 8'h40;
            4'd8:  k = 8'h21;
            4'd9:  k = 8'h35;
            4'd10: k = 8'hd5;
            4'd11: k = 8'h40;
            4'd12: k = 8'h13;
            4'd13: k = 8'h03;
            4'd14: k = 8'he9;
            default: k = 8'h80;
        endcase
        return k;
    endfunction

    // CRC16-XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/sfd_cell.sv]
// One byte cell of the frame buffer chain.
// Depends on sfd_pkg for the cell control struct.
`timescale 1ns / 1ps
module sfd_cell
    import sfd_pkg::*;
#(
    parameter int PW  = 7,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  cell_ctl_t     ctl,
    input  logic [PW-1:0] fill,
    input  logic [7:0]    head,
    input  logic [7:0]    right,
    output logic [7:0]    q
);

    localparam logic [PW-1:0] MyIdx = PW'(IDX);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        case (ctl.op)
            OP_LOAD: begin
                if (fill == MyIdx) byte_next = ctl.din;
            end
            OP_SHIFT: byte_next = right;
            OP_ROT: begin
                // tail of the occupied run takes the head back
                if (fill - PW'(1) == MyIdx) byte_next = head;
                else                        byte_next = right;
            end
            default: byte_next = byte_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

[rtl/serial_frame_deframer_descramble_crc.sv]
// Top level of the serial frame deframer with XOR descrambling and CRC16 check.
// Depends on sfd_pkg and sfd_cell.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_*: one received byte per transaction (s_tdata = rx_byte,
//   s_tlast = chunk_end, which does not affect parsing).
//   Master channel m_*: one transaction per payload byte of a completed frame,
//   or one for a frame without data; m_tlast marks the final one of a frame.
//   The buffer is a chain of byte cells that shift toward the head. After each
//   accepted byte the controller scans the head: a bad byte is dropped, a
//   packet check rotates the whole occupied chain once (CRC one byte per
//   cycle), and emission drops one byte per cycle while the output is not
//   stalled. s_tready is high only while the scan is done. The first result
//   is registered in the output register once emission reaches the payload.
//   A stalled m_tready freezes emission at the pending byte; the result stays
//   in the output register until taken.
//   Reset (aresetn low, synchronous) empties the buffer and clears the
//   discard count; buffer contents themselves are not cleared.
module serial_frame_deframer_descramble_crc
    import sfd_pkg::*;
#(
    parameter int BufferBytes = DefBufferBytes
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] msg_type, [15:8] value_a, [23:16] value_b, [31:24] value_c,
    // [39:32] field_byte, [47:40] data_byte, [48] data_valid,
    // [54:49] byte_index, [55] crc_ok, [71:56] discard_total
    output logic [71:0] m_tdata,
    output logic [0:0]  m_tuser,   // [0] frame_kind
    output logic        m_tlast    // last
);

    localparam int CW = $clog2(BufferBytes + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [16:0] BufW = 17'(BufferBytes);

    sfd_state_t state_reg, state_next;

    logic [PW-1:0] fill_reg, fill_next;
    logic [15:0]   disc_reg, disc_next;
    logic [PW-1:0] cnt_reg, cnt_next;     // rotation step or emission position
    logic [PW-1:0] size_reg, size_next;
    logic [PW-1:0] d0_reg, d0_next;       // first data position
    logic [PW-1:0] n_reg, n_next;         // data byte count
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   rx_reg, rx_next;
    logic          trail_ok_reg, trail_ok_next;
    logic          crc_ok_reg, crc_ok_next;
    logic          kind_reg, kind_next;
    logic [39:0]   hdr_reg, hdr_next;

    logic          mv_reg, mv_next;
    logic [71:0]   md_reg, md_next;
    logic          mk_reg, mk_next;
    logic          ml_reg, ml_next;

    cell_ctl_t     ctl;
    logic [7:0]    cell_q [BufferBytes];

    // cell chain
    for (genvar i = 0; i < BufferBytes; i++) begin : g_cell
        logic [7:0] right_w;
        if (i == BufferBytes - 1) begin : g_end
            assign right_w = 8'h00;
        end else begin : g_mid
            assign right_w = cell_q[i+1];
        end
        sfd_cell #(.PW(PW), .IDX(i)) u_cell (
            .aclk  (aclk),
            .ctl   (ctl),
            .fill  (fill_reg),
            .head  (cell_q[0]),
            .right (right_w),
            .q     (cell_q[i])
        );
    end

    // head decode
    logic [7:0]  b0, b1, b2, b3, b5;
    logic [16:0] fill_w, ui_size, pkt_len, pkt_size;
    logic        out_busy;
    assign b0 = cell_q[0];
    assign b1 = cell_q[1];
    assign b2 = cell_q[2];
    assign b3 = cell_q[3];
    assign b5 = cell_q[5];
    assign fill_w   = 17'(fill_reg);
    assign ui_size  = 17'd6 + ((b1 == UiNoData) ? 17'd0 : 17'(b5));
    assign pkt_len  = {1'b0, b3, b2};
    assign pkt_size = pkt_len + 17'd8;
    assign out_busy = mv_reg && !m_tready;

    // emission step decode
    logic [PW-1:0] rel;
    logic          is_data, is_empty, need_out, emit_go, emit_end;
    assign rel      = cnt_reg - d0_reg;
    assign is_data  = (cnt_reg >= d0_reg) && (rel < n_reg);
    assign is_empty = (n_reg == '0) && (cnt_reg == size_reg - PW'(1));
    assign need_out = is_data || is_empty;
    assign emit_go  = !(need_out && out_busy);
    assign emit_end = cnt_reg == size_reg - PW'(1);

    // check step decode
    logic [PW-1:0] krel;
    logic [7:0]    kbyte;
    assign krel  = cnt_reg - PW'(4);
    assign kbyte = b0 ^ scramble_key(krel[3:0]);

    function automatic logic [7:0] kbyte_emit(input logic [7:0] b, input logic [PW-1:0] r);
        return b ^ scramble_key(r[3:0]);
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (fill_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (b0 == UiSync) begin
                    if (fill_w < 17'd6)             state_next = ST_IDLE;
                    else if (ui_size > BufW)        state_next = ST_SCAN;
                    else if (fill_w < ui_size)      state_next = ST_IDLE;
                    else                            state_next = ST_EMIT;
                end else if (b0 == PktSync0) begin
                    if (fill_w < 17'd2)             state_next = ST_IDLE;
                    else if (b1 != PktSync1)        state_next = ST_SCAN;
                    else if (fill_w < 17'd4)        state_next = ST_IDLE;
                    else if (pkt_len < 17'd4)       state_next = ST_SCAN;
                    else if (pkt_size > BufW)       state_next = ST_SCAN;
                    else if (fill_w < pkt_size)     state_next = ST_IDLE;
                    else                            state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cnt_reg == fill_reg - PW'(1)) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = trail_ok_reg ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT: begin
                if (emit_go && emit_end) state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ctl.op        = OP_HOLD;
        ctl.din       = s_tdata;
        fill_next     = fill_reg;
        disc_next     = disc_reg;
        cnt_next      = cnt_reg;
        size_next     = size_reg;
        d0_next       = d0_reg;
        n_next        = n_reg;
        crc_next      = crc_reg;
        rx_next       = rx_reg;
        trail_ok_next = trail_ok_reg;
        crc_ok_next   = crc_ok_reg;
        kind_next     = kind_reg;
        hdr_next      = hdr_reg;
        mv_next       = mv_reg && !m_tready;
        md_next       = md_reg;
        mk_next       = mk_reg;
        ml_next       = ml_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (fill_reg < PW'(BufferBytes)) begin
                        ctl.op    = OP_LOAD;
                        fill_next = fill_reg + PW'(1);
                    end else if (disc_reg != DiscMax) begin
                        disc_next = disc_reg + 16'd1;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = '0;
                if (state_next == ST_SCAN && fill_reg != '0) begin
                    // drop the head byte
                    ctl.op    = OP_SHIFT;
                    fill_next = fill_reg - PW'(1);
                    if (disc_reg != DiscMax) disc_next = disc_reg + 16'd1;
                end else if (state_next == ST_EMIT) begin
                    kind_next   = 1'b0;
                    hdr_next    = {cell_q[5], cell_q[4], cell_q[3], cell_q[2], b1};
                    size_next   = ui_size[PW-1:0];
                    d0_next     = PW'(6);
                    n_next      = ui_size[PW-1:0] - PW'(6);
                    crc_ok_next = 1'b0;
                end else if (state_next == ST_CHECK) begin
                    kind_next     = 1'b1;
                    hdr_next      = '0;
                    size_next     = pkt_size[PW-1:0];
                    d0_next       = PW'(4);
                    n_next        = pkt_len[PW-1:0];
                    crc_next      = '0;
                    trail_ok_next = 1'b1;
                end
            end
            ST_CHECK: begin
                // rotate once around the occupied run
                ctl.op   = OP_ROT;
                cnt_next = cnt_reg + PW'(1);
                if (cnt_reg >= PW'(4) && krel < n_reg) crc_next = crc_byte(crc_reg, kbyte);
                if (krel == n_reg)          rx_next[7:0]  = kbyte;
                if (krel == n_reg + PW'(1)) rx_next[15:8] = kbyte;
                if (cnt_reg == size_reg - PW'(2) && b0 != PktTrail0) trail_ok_next = 1'b0;
                if (cnt_reg == size_reg - PW'(1) && b0 != PktTrail1) trail_ok_next = 1'b0;
            end
            ST_DECIDE: begin
                cnt_next    = '0;
                crc_ok_next = rx_reg == crc_reg;
                if (!trail_ok_reg) begin
                    ctl.op    = OP_SHIFT;
                    fill_next = fill_reg - PW'(1);
                    if (disc_reg != DiscMax) disc_next = disc_reg + 16'd1;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    ctl.op    = OP_SHIFT;
                    fill_next = fill_reg - PW'(1);
                    cnt_next  = cnt_reg + PW'(1);
                    if (need_out) begin
                        mv_next = 1'b1;
                        mk_next = kind_reg;
                        ml_next = is_empty || (rel == n_reg - PW'(1));
                        md_next[39:0]  = hdr_reg;
                        md_next[47:40] = is_empty ? 8'h00 :
                                         (kind_reg ? kbyte_emit(b0, rel) : b0);
                        md_next[48]    = is_data;
                        md_next[54:49] = is_data ? rel[5:0] : 6'd0;
                        md_next[55]    = crc_ok_reg;
                        md_next[71:56] = disc_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            disc_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            disc_reg  <= disc_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        size_reg     <= size_next;
        d0_reg       <= d0_next;
        n_reg        <= n_next;
        crc_reg      <= crc_next;
        rx_reg       <= rx_next;
        trail_ok_reg <= trail_ok_next;
        crc_ok_reg   <= crc_ok_next;
        kind_reg     <= kind_next;
        hdr_reg      <= hdr_next;
        md_reg       <= md_next;
        mk_reg       <= mk_next;
        ml_reg       <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mk_reg;
    assign m_tlast  = ml_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= PW'(BufferBytes))
        else $error("fill count beyond buffer size");

    a_scan_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again before scan");

    a_disc_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> disc_reg >= $past(disc_reg))
        else $error("discard count decreased");

    a_emit_data_in_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> fill_reg != '0)
        else $error("emission from an empty buffer");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking bench for serial_frame_deframer_descramble_crc.
// Drives received bytes, predicts decoded frames and checks each result.
// Depends on sfd_pkg and the deframer RTL.
`timescale 1ns / 1ps
module tb_top
    import sfd_pkg::*;
;

    localparam int BufBytes    = 64;
    localparam int ItemTarget  = 310;
    localparam int QuietFrom   = 260;   // no idling on either side past this point
    localparam int HoldAt      = 120;   // item count at which the long receiver hold starts
    localparam int HoldCycles  = 400;
    localparam int WatchLimit  = 5000;
    localparam int DrainCycles = 300;

    // one decoded frame byte, as carried on the master channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  mtype;
        logic [7:0]  val_a;
        logic [7:0]  val_b;
        logic [7:0]  val_c;
        logic [7:0]  field;
        logic [7:0]  data;
        logic        dvalid;
        logic [5:0]  idx;
        logic        last;
        logic        crc_ok;
        logic [15:0] disc;
    } frame_byte_t;

    typedef struct {
        logic [7:0]  rx;
        logic        cend;
        bit          typed;     // row carries a hand-written expectation
        frame_byte_t want;
    } rx_item_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    serial_frame_deframer_descramble_crc dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // descrambling key, independent copy
    logic [7:0] descr_key [16] = '{8'h16, 8'h6c, 8'h14, 8'he6, 8'h2e, 8'h91, 8'h0d, 8'h40,
                                   8'h21, 8'h35, 8'hd5, 8'h40, 8'h13, 8'h03, 8'he9, 8'h80};

    logic [7:0]  rx_fifo[$];          // predictor's copy of the frame buffer
    logic [15:0] discard_cnt;
    frame_byte_t frames_due[$];       // decoded bytes still awaited from the block
    rx_item_t    stim[$];
    int          err_cnt = 0;
    int          sent = 0;
    bit          quiet = 0;
    bit          hold_req = 0;
    bit          moved;

    function automatic logic [15:0] xmodem_update(logic [15:0] c, logic [7:0] b);
        c ^= {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic void count_discard();
        if (discard_cnt != DiscMax) discard_cnt++;
    endfunction

    function automatic void drop_head(int n);
        repeat (n) void'(rx_fifo.pop_front());
    endfunction

    // Append one byte (or count it as discarded when the buffer is full) and decode whatever the buffer now holds.
    function automatic void decode_rx(logic [7:0] b);
        int          sz, len;
        logic [15:0] crc, rcv;
        logic [7:0]  d;
        frame_byte_t fb;
        if (rx_fifo.size() < BufBytes) rx_fifo.insert(rx_fifo.size(), b);
        else count_discard();
        while (rx_fifo.size() > 0) begin
            fb = '0;
            if (rx_fifo[0] == UiSync) begin
                if (rx_fifo.size() < 6) break;
                sz = 6 + ((rx_fifo[1] == UiNoData) ? 0 : int'(rx_fifo[5]));
                if (sz > BufBytes) begin
                    drop_head(1); count_discard(); continue;
                end
                if (rx_fifo.size() < sz) break;
                fb.mtype = rx_fifo[1]; fb.val_a = rx_fifo[2]; fb.val_b = rx_fifo[3];
                fb.val_c = rx_fifo[4]; fb.field = rx_fifo[5]; fb.disc = discard_cnt;
                if (sz == 6) begin
                    fb.last = 1'b1;
                    frames_due.insert(frames_due.size(), fb);
                end
                for (int i = 0; i < sz - 6; i++) begin
                    fb.data = rx_fifo[6 + i]; fb.dvalid = 1'b1; fb.idx = i[5:0];
                    fb.last = (i == sz - 7);
                    frames_due.insert(frames_due.size(), fb);
                end
                drop_head(sz);
            end else if (rx_fifo[0] == PktSync0) begin
                if (rx_fifo.size() < 2) break;
                if (rx_fifo[1] != PktSync1) begin
                    drop_head(1); count_discard(); continue;
                end
                if (rx_fifo.size() < 4) break;
                len = int'({rx_fifo[3], rx_fifo[2]});
                sz  = len + 8;
                if (len < 4 || sz > BufBytes) begin
                    drop_head(1); count_discard(); continue;
                end
                if (rx_fifo.size() < sz) break;
                if (rx_fifo[sz - 2] != PktTrail0 || rx_fifo[sz - 1] != PktTrail1) begin
                    drop_head(1); count_discard(); continue;
                end
                crc = '0;
                for (int i = 0; i < len; i++)
                    crc = xmodem_update(crc, rx_fifo[4 + i] ^ descr_key[i % 16]);
                rcv = {rx_fifo[5 + len] ^ descr_key[(len + 1) % 16],
                       rx_fifo[4 + len] ^ descr_key[len % 16]};
                fb.kind = 1'b1; fb.disc = discard_cnt; fb.crc_ok = (rcv == crc);
                for (int i = 0; i < len; i++) begin
                    d = rx_fifo[4 + i] ^ descr_key[i % 16];
                    fb.data = d; fb.dvalid = 1'b1; fb.idx = i[5:0]; fb.last = (i == len - 1);
                    frames_due.insert(frames_due.size(), fb);
                end
                drop_head(sz);
            end else begin
                drop_head(1); count_discard();
            end
        end
    endfunction

    function automatic void add_byte(logic [7:0] b);
        rx_item_t it;
        it.rx = b; it.cend = 1'($urandom_range(0, 1)); it.typed = 0; it.want = '0;
        stim.insert(stim.size(), it);
    endfunction

    // Scramble a packet of plain payload; optionally spoil its CRC or trailer.
    function automatic void add_packet(int len, bit bad_crc, bit bad_trail);
        logic [7:0]  p;
        logic [15:0] crc = '0;
        add_byte(PktSync0); add_byte(PktSync1);
        add_byte(len[7:0]); add_byte(len[15:8]);
        for (int i = 0; i < len; i++) begin
            p = (i == 1) ? 8'hFF : ((i == 0) ? 8'h00 : 8'($urandom));
            crc = xmodem_update(crc, p);
            add_byte(p ^ descr_key[i % 16]);
        end
        if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
        add_byte(crc[7:0] ^ descr_key[len % 16]);
        add_byte(crc[15:8] ^ descr_key[(len + 1) % 16]);
        add_byte(bad_trail ? 8'hDB : PktTrail0);
        add_byte(bad_trail ? 8'($urandom) : PktTrail1);
    endfunction

    function automatic void add_ui(logic [7:0] t, int flen);
        add_byte(UiSync); add_byte(t);
        repeat (3) add_byte(8'($urandom));
        add_byte(8'(flen));
        if (t != UiNoData) repeat (flen) add_byte(8'($urandom));
    endfunction

    function automatic void add_typed(logic [7:0] b, bit typed, frame_byte_t want);
        rx_item_t it;
        it.rx = b; it.cend = b[0]; it.typed = typed; it.want = want;
        stim.insert(stim.size(), it);
    endfunction

    // Random traffic: mostly well-formed frames, the rest broken frames and noise.
    function automatic void add_random_frame();
        int r = $urandom_range(0, 99);
        logic [7:0] t = 8'($urandom);
        if (r < 30) begin
            if ($urandom_range(0, 4) == 0) add_ui(UiNoData, $urandom_range(0, 255));
            else add_ui((t == UiNoData) ? 8'h07 : t,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 58) : $urandom_range(0, 6));
        end else if (r < 60) begin
            add_packet(($urandom_range(0, 9) == 0) ? $urandom_range(4, 56) : $urandom_range(4, 10),
                       0, 0);
        end else if (r < 67) add_packet($urandom_range(4, 10), 1, 0);
        else if (r < 72) add_packet($urandom_range(4, 10), 0, 1);
        else if (r < 76) add_packet($urandom_range(0, 3), 0, 0);
        else if (r < 80) begin
            add_byte(PktSync0); add_byte(PktSync1);
            add_byte(8'($urandom_range(57, 255))); add_byte(8'($urandom));
        end else if (r < 84) add_ui((t == UiNoData) ? 8'h00 : t, $urandom_range(59, 255));
        else if (r < 88) begin
            add_byte(PktSync0); add_byte((t == PktSync1) ? 8'h00 : t);
        end else repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    endfunction

    // Offer one byte until the block takes it, then update the prediction.
    task automatic send_rx(rx_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.rx;
        s_tlast  <= it.cend;
        do @(posedge aclk); while (!s_tready);
        decode_rx(it.rx);
        sent++;
        if (it.typed && (frames_due.size() == 0 || frames_due[$] != it.want)) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("directed row mismatch: want %h got %h", it.want,
                         (frames_due.size() != 0) ? frames_due[$] : '0);
        end
        if (sent == HoldAt) hold_req = 1;
        if (sent == QuietFrom) quiet = 1;
    endtask

    // Receiver: random stall bursts, one long hold so the buffer backs up.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Check each result transaction against the oldest predicted byte.
    always @(posedge aclk) begin
        frame_byte_t got, exp_fb;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                   m_tdata[39:32], m_tdata[47:40], m_tdata[48], m_tdata[54:49], m_tlast,
                   m_tdata[55], m_tdata[71:56]};
            if (frames_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result: %p", got);
            end else begin
                exp_fb = frames_due.pop_front();
                if (got.kind !== exp_fb.kind || got.mtype !== exp_fb.mtype ||
                    got.val_a !== exp_fb.val_a || got.val_b !== exp_fb.val_b ||
                    got.val_c !== exp_fb.val_c || got.field !== exp_fb.field ||
                    got.data !== exp_fb.data || got.dvalid !== exp_fb.dvalid ||
                    got.idx !== exp_fb.idx || got.last !== exp_fb.last ||
                    got.crc_ok !== exp_fb.crc_ok || got.disc !== exp_fb.disc) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("mismatch: expected %p actual %p", exp_fb, got);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        forever begin
            @(posedge aclk);
            moved = (s_tvalid && s_tready) || (m_tvalid && m_tready);
            idle_cyc = moved ? 0 : idle_cyc + 1;
            if (idle_cyc >= WatchLimit) begin
                $display("watchdog expired");
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        discard_cnt = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: two bad bytes, a no-data UI frame, a one-byte UI frame, a packet
        add_typed(8'h00, 0, '0);
        add_typed(8'hFF, 0, '0);
        add_typed(UiSync, 0, '0); add_typed(UiNoData, 0, '0); add_typed(8'h00, 0, '0);
        add_typed(8'hFF, 0, '0);  add_typed(8'h80, 0, '0);
        add_typed(8'hFF, 1, '{1'b0, 8'h06, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 1'b0,
                              6'd0, 1'b1, 1'b0, 16'd2});
        add_typed(UiSync, 0, '0); add_typed(8'h01, 0, '0); add_typed(8'hFF, 0, '0);
        add_typed(8'h00, 0, '0);  add_typed(8'h7F, 0, '0); add_typed(8'h01, 0, '0);
        add_typed(8'hAA, 1, '{1'b0, 8'h01, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'hAA, 1'b1,
                              6'd0, 1'b1, 1'b0, 16'd2});
        add_packet(4, 0, 0);
        while (stim.size() > 0) send_rx(stim.pop_front());

        while (sent < ItemTarget) begin
            add_random_frame();
            while (stim.size() > 0) send_rx(stim.pop_front());
        end
        s_tvalid <= 1'b0;

        while (frames_due.size() > 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (err_cnt == 0 && frames_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
